>>> rtl/dtoi_pkg.sv
`timescale 1ns / 1ps
package dtoi_pkg;

    localparam int CH_W    = 8;
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 64;
    localparam int HALF_W  = 32;
    localparam int DIGIT_W = 4;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [FUNC_W-1:0] MODE_S32 = 2'd0;
    localparam logic [FUNC_W-1:0] MODE_U32 = 2'd1;

    localparam logic [CH_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;

    // Work queued from the classifier to the accumulator.
    typedef enum logic [1:0] {
        OP_DIGIT,
        OP_NEG,
        OP_BAD,
        OP_TERM
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
        logic [FUNC_W-1:0]  mode;
    } t_cmd;

endpackage

>>> rtl/dtoi_in_if.sv
`timescale 1ns / 1ps
interface dtoi_in_if
    import dtoi_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   ch;
    logic [FUNC_W-1:0] func;

    modport source (output valid, output ch, output func, input ready);
    modport sink (input valid, input ch, input func, output ready);
endinterface

>>> rtl/dtoi_out_if.sv
`timescale 1ns / 1ps
interface dtoi_out_if
    import dtoi_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               rejected;

    modport source (output valid, output value, output rejected, input ready);
    modport sink (input valid, input value, input rejected, output ready);
endinterface

>>> rtl/decimal_text_to_integer_unit.sv
`timescale 1ns / 1ps
// Channel   Port    Dir  Payload                        Beat
// --------  ------  ---  -----------------------------  -------------------------
// text in   i_in    in   ch[7:0], func[1:0]             one character per beat
// result    o_out   out  value[63:0], rejected          one beat per terminator
//
// One character per cycle sustained while the queue has room; a terminator beat is
// written into the queue when it is taken and moves to the output register when the
// back end pops it; the result beat is valid after both, later under a stall.
// The single times-ten add on the 64-bit accumulator sets the pace.
// Synchronous active-low reset clears field state, queue and output valid.
// A stalled result holds the back end only at the next terminator; the queue
// absorbs the stall and i_in.ready drops once the queue is full.
module decimal_text_to_integer_unit
    import dtoi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtoi_in_if.sink    i_in,
    dtoi_out_if.source o_out
);

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;

    // queue to back end
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // Classify each character, track field start and mode, drop a leading plus.
    dtoi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // Decouple the classifier from the accumulator so each may stall alone.
    dtoi_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // Fold digits, apply sign and width, register the result beat.
    dtoi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> rtl/dtoi_front.sv
`timescale 1ns / 1ps
module dtoi_front
    import dtoi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtoi_in_if.sink    i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic              r_at_start;
    logic [FUNC_W-1:0] r_mode;
    logic              n_at_start;
    logic [FUNC_W-1:0] n_mode;

    logic              accept;
    logic              keep;
    t_cmd              cmd;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        cmd.mode   = r_at_start ? i_in.func : r_mode;
        // low nibble of an ASCII digit is its value
        cmd.digit  = i_in.ch[DIGIT_W-1:0];
        cmd.op     = OP_BAD;
        keep       = 1'b1;
        n_at_start = r_at_start;
        n_mode     = r_mode;
        if (accept) begin
            n_at_start = (i_in.ch == CHAR_NUL);
            if (r_at_start) begin
                n_mode = i_in.func;
            end
        end
        if (i_in.ch == CHAR_NUL) begin
            cmd.op = OP_TERM;
        end else if (r_at_start && i_in.ch == CHAR_MINUS) begin
            // minus only counts in signed mode
            cmd.op = (cmd.mode == MODE_S32) ? OP_NEG : OP_BAD;
        end else if (r_at_start && i_in.ch == CHAR_PLUS) begin
            keep = 1'b0;
        end else if (i_in.ch >= CHAR_ZERO && i_in.ch <= CHAR_NINE) begin
            cmd.op = OP_DIGIT;
        end
    end

    assign o_push = accept && keep;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
            r_mode     <= MODE_S32;
        end else begin
            r_at_start <= n_at_start;
            r_mode     <= n_mode;
        end
    end

    a_term_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.ch == CHAR_NUL) |=> r_at_start)
        else $error("field start not restored after terminator");

endmodule

>>> rtl/dtoi_queue.sv
`timescale 1ns / 1ps
module dtoi_queue
    import dtoi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

>>> rtl/dtoi_back.sv
`timescale 1ns / 1ps
module dtoi_back
    import dtoi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    dtoi_out_if.source o_out
);

    logic [VALUE_W-1:0] r_acc;
    logic               r_neg;
    logic               r_bad;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_value;
    logic               r_rejected;

    logic               out_free;
    logic               narrow;
    logic [VALUE_W-1:0] times_ten;
    logic [VALUE_W-1:0] next_acc;
    logic [HALF_W-1:0]  lo;
    logic [HALF_W-1:0]  lo_signed;
    logic [VALUE_W-1:0] result;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = i_valid && ((i_cmd.op != OP_TERM) || out_free);
    assign narrow   = (i_cmd.mode == MODE_S32) || (i_cmd.mode == MODE_U32);

    always_comb begin
        times_ten = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0};
        next_acc  = times_ten + VALUE_W'(i_cmd.digit);
        if (narrow) begin
            next_acc[VALUE_W-1:HALF_W] = '0;
        end
        lo        = r_acc[HALF_W-1:0];
        lo_signed = r_neg ? (~lo + 1'b1) : lo;
        if (r_bad) begin
            result = '0;
        end else if (i_cmd.mode == MODE_S32) begin
            result = {{HALF_W{lo_signed[HALF_W-1]}}, lo_signed};
        end else if (i_cmd.mode == MODE_U32) begin
            result = {{HALF_W{1'b0}}, lo};
        end else begin
            result = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                case (i_cmd.op)
                    OP_DIGIT: r_acc <= next_acc;
                    OP_NEG:   r_neg <= 1'b1;
                    OP_BAD:   r_bad <= 1'b1;
                    OP_TERM: begin
                        r_acc <= '0;
                        r_neg <= 1'b0;
                        r_bad <= 1'b0;
                    end
                    default:  r_acc <= r_acc;
                endcase
            end
            if (o_pop && i_cmd.op == OP_TERM) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.op == OP_TERM) begin
            r_value    <= result;
            r_rejected <= r_bad;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.value    = r_value;
    assign o_out.rejected = r_rejected;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rejected) |-> (o_out.value == '0))
        else $error("rejected result carries non-zero value");

    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.op == OP_TERM) |=> (r_acc == '0 && !r_neg && !r_bad))
        else $error("field state not cleared after terminator");

endmodule

>>> bench/decimal_text_to_integer_unit_tb.sv
`timescale 1ns / 1ps
module decimal_text_to_integer_unit_tb;
    import dtoi_pkg::*;

    // Mode codes the package leaves unnamed; the spare code behaves as unsigned 64-bit.
    localparam logic [FUNC_W-1:0] MODE_U64   = 2'd2;
    localparam logic [FUNC_W-1:0] MODE_SPARE = 2'd3;

    localparam logic [VALUE_W-1:0] LOW32_MASK = 64'h0000_0000_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] DEC_RADIX  = 64'd10;

    localparam int RESET_CYCLES    = 10;
    localparam int IDLE_PCT        = 31;    // chance in a hundred that a side idles
    localparam int ITEM_TARGET     = 1250;
    localparam int STALL_PHASE_LEN = 80;    // characters offered while the sink holds off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STEADY_FROM     = 500;   // window with no idling on either side
    localparam int STEADY_TO       = 800;
    localparam int SETTLE_CYCLES   = 8;     // a result passes the queue and the output register after its terminator
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic [CH_W-1:0]   ch;
        logic [FUNC_W-1:0] func;
    } t_text_beat;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               rejected;
    } t_parsed;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtoi_in_if  text_if ();
    dtoi_out_if result_if ();

    decimal_text_to_integer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (text_if),
        .o_out   (result_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_text_beat text_q[$];      // characters waiting to be offered
    t_parsed    parsed_q[$];    // numbers the block owes, oldest first

    // Predictor state: the field being parsed.
    logic [VALUE_W-1:0] sum_acc      = '0;
    logic               sum_negative = 1'b0;
    logic               sum_rejected = 1'b0;
    logic               sum_at_start = 1'b1;
    logic [FUNC_W-1:0]  sum_mode     = MODE_S32;

    // Run control: steady and the hold-off request are written by the stimulus process at the falling edge.
    bit steady        = 1'b0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int hold_left     = 0;

    int chars_queued   = 0;
    int chars_accepted = 0;
    int results_seen   = 0;
    int rejects_seen   = 0;
    int error_count    = 0;
    int idle_run       = 0;

    function automatic void note_error(string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endfunction

    // Fold one accepted character into the field; on the terminator, queue the number owed.
    function automatic void fold_char(logic [CH_W-1:0] c, logic [FUNC_W-1:0] f);
        logic               first;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] v;
        logic [HALF_W-1:0]  lo;
        t_parsed            owed;
        first = sum_at_start;
        if (first) begin
            sum_mode     = f;
            sum_at_start = 1'b0;
        end
        mask = (sum_mode == MODE_S32 || sum_mode == MODE_U32) ? LOW32_MASK : {VALUE_W{1'b1}};
        if (c == CHAR_NUL) begin
            v = sum_acc & mask;
            if (sum_mode == MODE_S32) begin
                // negate modulo 2^32, then sign-extend
                lo = v[HALF_W-1:0];
                if (sum_negative) begin
                    lo = -lo;
                end
                v = {{HALF_W{lo[HALF_W-1]}}, lo};
            end
            owed.value    = sum_rejected ? '0 : v;
            owed.rejected = sum_rejected;
            parsed_q.push_back(owed);
            sum_acc      = '0;
            sum_negative = 1'b0;
            sum_rejected = 1'b0;
            sum_at_start = 1'b1;
        end else if (first && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
            if (c == CHAR_MINUS) begin
                if (sum_mode == MODE_S32) begin
                    sum_negative = 1'b1;
                end else begin
                    sum_rejected = 1'b1;
                end
            end
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            sum_acc = (sum_acc * DEC_RADIX + VALUE_W'(c - CHAR_ZERO)) & mask;
        end else begin
            sum_rejected = 1'b1;
        end
    endfunction

    // Driver: hold a beat until taken, then pop the next one or idle at random.
    always @(posedge i_clk) begin : drive_text
        t_text_beat beat;
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
        end else begin
            if (text_if.valid && text_if.ready) begin
                fold_char(text_if.ch, text_if.func);
                chars_accepted++;
            end
            if (!text_if.valid || text_if.ready) begin
                if (text_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    beat = text_q.pop_front();
                    text_if.valid <= 1'b1;
                    text_if.ch    <= beat.ch;
                    text_if.func  <= beat.func;
                end else begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest number owed, then pick ready.
    always @(posedge i_clk) begin : watch_result
        t_parsed want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                results_seen++;
                if (result_if.rejected) begin
                    rejects_seen++;
                end
                if (parsed_q.size() == 0) begin
                    note_error($sformatf("unexpected result value=%h rejected=%b",
                                         result_if.value, result_if.rejected));
                end else begin
                    want = parsed_q.pop_front();
                    if (result_if.value !== want.value || result_if.rejected !== want.rejected) begin
                        note_error($sformatf("value exp %h got %h, rejected exp %b got %b",
                                             want.value, result_if.value,
                                             want.rejected, result_if.rejected));
                    end
                end
            end
            // hold off once for a long stretch so the block backs up into its input
            if (hold_left != 0) begin
                hold_left       <= hold_left - 1;
                result_if.ready <= 1'b0;
            end else if (hold_off_req && !hold_off_done) begin
                hold_off_done   <= 1'b1;
                hold_left       <= HOLD_OFF_CYCLES;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((text_if.valid && text_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results still owed",
                     idle_run, parsed_q.size());
            $display("decimal_text_to_integer_unit_tb failed");
            $finish;
        end
    end

    task automatic queue_char(input logic [CH_W-1:0] c, input logic [FUNC_W-1:0] f);
        t_text_beat beat;
        beat.ch   = c;
        beat.func = f;
        text_q.push_back(beat);
        chars_queued++;
    endtask

    // One field of random shape: mostly well-formed, some with a stray character, some noise.
    task automatic queue_random_field();
        logic [FUNC_W-1:0] mode;
        logic [CH_W-1:0]   junk;
        logic [CH_W-1:0]   text[$];
        int unsigned       shape;
        int unsigned       sign_pick;
        int unsigned       len;
        mode      = FUNC_W'($urandom_range(3));
        shape     = $urandom_range(99);
        sign_pick = $urandom_range(9);
        // mostly up to 10 digits, a quarter up to 24 digits so some wrap 64 bits
        len = ($urandom_range(3) == 0) ? $urandom_range(24) : $urandom_range(10);
        if (shape < 88) begin
            if (sign_pick < 2) begin
                text.push_back(CHAR_MINUS);
            end else if (sign_pick < 4) begin
                text.push_back(CHAR_PLUS);
            end
            for (int i = 0; i < len; i++) begin
                text.push_back(CHAR_ZERO + CH_W'($urandom_range(9)));
            end
            if (shape >= 70) begin
                do begin
                    junk = CH_W'($urandom_range(1, 255));
                end while (junk >= CHAR_ZERO && junk <= CHAR_NINE);
                text.insert($urandom_range(text.size()), junk);
            end
        end else begin
            len = $urandom_range(6);
            for (int i = 0; i < len; i++) begin
                text.push_back(CH_W'($urandom_range(1, 255)));
            end
        end
        // only the first character carries the mode; scramble func on the rest
        foreach (text[i]) begin
            queue_char(text[i], (i == 0) ? mode : FUNC_W'($urandom_range(3)));
        end
        queue_char(CHAR_NUL, (text.size() == 0) ? mode : FUNC_W'($urandom_range(3)));
    endtask

    // Wait until every character is taken and every number owed has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        while (text_q.size() != 0 || text_if.valid || parsed_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin : stimulus
        i_rst_n         = 1'b0;
        text_if.valid   = 1'b0;
        text_if.ch      = CHAR_NUL;
        text_if.func    = MODE_S32;
        result_if.ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty field, lone signs, negatives, unsigned minus, double sign,
        // stray letter, all-ones byte under the spare mode, a mode that changes mid-field.
        queue_char(CHAR_NUL, MODE_S32);
        queue_char(CHAR_PLUS, MODE_S32);
        queue_char(CHAR_NUL, MODE_U32);
        queue_char(CHAR_MINUS, MODE_S32);
        queue_char(CHAR_NUL, MODE_S32);
        queue_char(CHAR_MINUS, MODE_S32);
        queue_char(CHAR_NINE, MODE_SPARE);
        queue_char(CHAR_NUL, MODE_SPARE);
        queue_char(CHAR_MINUS, MODE_U32);
        queue_char(CHAR_ZERO + 8'd5, MODE_U32);
        queue_char(CHAR_NUL, MODE_U32);
        queue_char(CHAR_PLUS, MODE_S32);
        queue_char(CHAR_MINUS, MODE_S32);
        queue_char(CHAR_NUL, MODE_S32);
        queue_char(CHAR_ZERO + 8'd7, MODE_U64);
        queue_char("A", MODE_U64);
        queue_char(CHAR_NUL, MODE_U64);
        queue_char(8'hFF, MODE_SPARE);
        queue_char(CHAR_NUL, MODE_SPARE);
        queue_char(CHAR_NINE, MODE_U32);
        queue_char(CHAR_ZERO, MODE_U64);
        queue_char(CHAR_NUL, MODE_S32);

        // Pause the sender until the directed results are all back.
        wait_drained();

        // Hold off the sink while the sender keeps offering, so the input stalls.
        hold_off_req = 1'b1;
        while (chars_queued < 22 + STALL_PHASE_LEN) begin
            queue_random_field();
        end
        wait_drained();

        // Random bulk; feed in small batches so the steady window lands mid-run.
        while (chars_queued < ITEM_TARGET) begin
            while (text_q.size() > 8) begin
                @(negedge i_clk);
            end
            steady = (chars_queued >= STEADY_FROM) && (chars_queued < STEADY_TO);
            queue_random_field();
        end
        wait_drained();
        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (parsed_q.size() != 0) begin
            note_error($sformatf("%0d results never arrived", parsed_q.size()));
        end
        $display("parsed %0d characters into %0d numbers (%0d rejected fields)",
                 chars_accepted, results_seen, rejects_seen);
        $display("modes s32/u32/u64/spare, wrap, signs, stalls; %0d errors", error_count);
        if (error_count == 0) begin
            $display("decimal_text_to_integer_unit_tb passed");
        end else begin
            $display("decimal_text_to_integer_unit_tb failed");
        end
        $finish;
    end

endmodule
